// ===== hdl/ttu_pkg.sv =====
// Shared types, codes and constants for the tick-timed UART with receive FIFO.
`timescale 1ns / 1ps

package ttu_pkg;

  // Host command codes as they arrive on func
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_WRITE   = 3'd1;
  localparam logic [2:0] FUNC_POP     = 3'd2;
  localparam logic [2:0] FUNC_FLUSH   = 3'd3;
  localparam logic [2:0] FUNC_CLR_OVF = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_RX_ENABLE = 3'd0;
  localparam logic [2:0] CFG_RX_CENTER = 3'd1;
  localparam logic [2:0] CFG_RX_BIT    = 3'd2;
  localparam logic [2:0] CFG_RX_STOP   = 3'd3;
  localparam logic [2:0] CFG_TX_BIT    = 3'd4;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam logic [16:0] TX_START_EXTRA = 17'd5;

  // Beats of room kept in the result queue
  localparam int OQ_DEPTH = 4;
  // Command queue between front and back
  localparam int CQ_DEPTH = 2;

  // Classified command
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_POP,
    CMD_FLUSH,
    CMD_CLR_OVF
  } cmd_t;

  // Receiver / transmitter frame phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_DATA,
    PH_STOP
  } phase_t;

  // One tick as handed from front to back
  typedef struct packed {
    cmd_t       op;
    logic       rx_line;
    logic [7:0] tx_data;
  } tick_t;

  // One result beat
  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       write_accepted;
    logic [7:0] pop_data;
    logic       pop_valid;
    logic [7:0] head_data;
    logic [3:0] bytes_available;
    logic       overflow;
  } res_t;

  // Configuration write beat
  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// ===== hdl/tick_timed_uart_with_rx_fifo_unit.sv =====
// Top level: tick-timed 8N1 UART transceiver with receive FIFO.
//
//   channel   direction  handshake         beat carries
//   ticks     in         push / full       func, rx_line, tx_data
//   results   out        empty / pop       tx_line .. overflow (eight fields)
//   config    in         cfg_valid / ready cfg_index, cfg_data
//
// One tick is accepted per clock while full is low; its result beat passes the
// tick queue, the tick stage with its registered FIFO read, then the result queue.
// The receiver, FIFO and transmitter state update once per tick.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// A stalled result port fills a four-beat result queue, then a two-beat
// tick queue, after which full rises.
`timescale 1ns / 1ps

module tick_timed_uart_with_rx_fifo_unit #(
  parameter int FIFO_DEPTH = ttu_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func,
  input  logic        rx_line,
  input  logic [7:0]  tx_data,
  output logic        empty,
  input  logic        pop,
  output logic        tx_line,
  output logic        tx_busy,
  output logic        write_accepted,
  output logic [7:0]  pop_data,
  output logic        pop_valid,
  output logic [7:0]  head_data,
  output logic [3:0]  bytes_available,
  output logic        overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic             tick_valid;
  ttu_pkg::tick_t   tick;
  logic             tick_take;
  logic             credit_ok;
  logic             res_valid;
  ttu_pkg::res_t    res;
  ttu_pkg::res_t    head;
  ttu_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

  ttu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .rx_line    (rx_line),
    .tx_data    (tx_data),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take)
  );

  ttu_core #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .credit_ok  (credit_ok),
    .res_valid  (res_valid),
    .res        (res)
  );

  ttu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .credit_ok (credit_ok),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign tx_line         = head.tx_line;
  assign tx_busy         = head.tx_busy;
  assign write_accepted  = head.write_accepted;
  assign pop_data        = head.pop_data;
  assign pop_valid       = head.pop_valid;
  assign head_data       = head.head_data;
  assign bytes_available = head.bytes_available;
  assign overflow        = head.overflow;

endmodule

// ===== hdl/ttu_front.sv =====
// Front end: accepts ticks, classifies the command, queues them for the back end.
`timescale 1ns / 1ps

module ttu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        func,
  input  logic              rx_line,
  input  logic [7:0]        tx_data,
  output logic              tick_valid,
  output ttu_pkg::tick_t    tick,
  input  logic              tick_take
);

  localparam int PW = $clog2(ttu_pkg::CQ_DEPTH);
  localparam int CW = $clog2(ttu_pkg::CQ_DEPTH + 1);

  ttu_pkg::tick_t slots [ttu_pkg::CQ_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  ttu_pkg::cmd_t  op;
  logic           do_push;
  logic           do_pop;

  // Command decode; unused codes act as a plain tick
  always_comb begin
    unique case (func)
      ttu_pkg::FUNC_TICK:    op = ttu_pkg::CMD_TICK;
      ttu_pkg::FUNC_WRITE:   op = ttu_pkg::CMD_WRITE;
      ttu_pkg::FUNC_POP:     op = ttu_pkg::CMD_POP;
      ttu_pkg::FUNC_FLUSH:   op = ttu_pkg::CMD_FLUSH;
      ttu_pkg::FUNC_CLR_OVF: op = ttu_pkg::CMD_CLR_OVF;
      default:               op = ttu_pkg::CMD_TICK;
    endcase
  end

  assign full       = (count == CW'(ttu_pkg::CQ_DEPTH));
  assign tick_valid = (count != '0);
  assign tick       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = tick_take && tick_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= '{op: op, rx_line: rx_line, tx_data: tx_data};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(ttu_pkg::CQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(ttu_pkg::CQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== hdl/ttu_core.sv =====
// Back end: receiver, receive ring FIFO and transmitter, one tick per beat.
`timescale 1ns / 1ps

module ttu_core #(
  parameter int FIFO_DEPTH = ttu_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ttu_pkg::cfg_wr_t cfg_wr,
  input  logic             tick_valid,
  input  ttu_pkg::tick_t   tick,
  output logic             tick_take,
  input  logic             credit_ok,
  output logic             res_valid,
  output ttu_pkg::res_t    res
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = (PW + 1 > 4) ? PW + 1 : 4;

  // Configuration registers
  logic        rx_enable;
  logic [15:0] rx_center_ticks;
  logic [15:0] rx_bit_ticks;
  logic [15:0] rx_stop_ticks;
  logic [15:0] tx_bit_ticks;

  // Architectural state
  logic [PW-1:0]   fifo_head, fifo_head_next;
  logic [PW-1:0]   fifo_tail, fifo_tail_next;
  logic            overflow_flag, overflow_flag_next;
  ttu_pkg::phase_t rx_phase, rx_phase_next;
  logic [15:0]     rx_timer, rx_timer_next;
  logic [3:0]      rx_bit_count, rx_bit_count_next;
  logic [7:0]      rx_shift, rx_shift_next;
  ttu_pkg::phase_t tx_phase, tx_phase_next;
  logic [16:0]     tx_timer, tx_timer_next;
  logic [3:0]      tx_bit_count, tx_bit_count_next;
  logic [7:0]      tx_shift, tx_shift_next;
  logic            tx_level, tx_level_next;

  // Receive FIFO storage
  logic [7:0]    fifo_store [FIFO_DEPTH];
  logic [7:0]    rd_pop;
  logic [7:0]    rd_head;

  // Tick-stage combinational results
  logic          a_fire;
  logic          mem_we;
  logic [PW-1:0] tail_mid;
  logic          pop_ok;
  logic          accepted;
  logic [3:0]    rx_cnt_inc;
  logic [3:0]    tx_cnt_inc;
  logic [16:0]   tx_dec;
  logic [CW-1:0] avail;

  // Read-out stage registers
  logic          b_valid;
  logic          b_tx_line;
  logic          b_tx_busy;
  logic          b_accepted;
  logic          b_pop_valid;
  logic          b_pop_byp;
  logic          b_head_ne;
  logic          b_head_byp;
  logic [7:0]    b_wbyte;
  logic [3:0]    b_avail;
  logic          b_overflow;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
    ring_next = (i == PW'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // A tick runs only when the result queue can take its beat
  assign a_fire    = tick_valid && credit_ok;
  assign tick_take = a_fire;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable       <= 1'b0;
      rx_center_ticks <= '0;
      rx_bit_ticks    <= '0;
      rx_stop_ticks   <= '0;
      tx_bit_ticks    <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        ttu_pkg::CFG_RX_ENABLE: rx_enable       <= cfg_wr.data[0];
        ttu_pkg::CFG_RX_CENTER: rx_center_ticks <= cfg_wr.data;
        ttu_pkg::CFG_RX_BIT:    rx_bit_ticks    <= cfg_wr.data;
        ttu_pkg::CFG_RX_STOP:   rx_stop_ticks   <= cfg_wr.data;
        ttu_pkg::CFG_TX_BIT:    tx_bit_ticks    <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Receiver, then FIFO command
  always_comb begin
    rx_phase_next      = rx_phase;
    rx_timer_next      = rx_timer;
    rx_bit_count_next  = rx_bit_count;
    rx_shift_next      = rx_shift;
    overflow_flag_next = overflow_flag;
    mem_we             = 1'b0;
    tail_mid           = fifo_tail;
    rx_cnt_inc         = rx_bit_count + 4'd1;

    unique case (rx_phase)
      ttu_pkg::PH_IDLE: begin
        if (rx_enable && !tick.rx_line) begin
          rx_phase_next     = ttu_pkg::PH_FIRST;
          rx_timer_next     = rx_center_ticks;
          rx_bit_count_next = '0;
          rx_shift_next     = '0;
        end
      end
      ttu_pkg::PH_FIRST: begin
        if (rx_timer != '0) begin
          rx_timer_next = rx_timer - 16'd1;
        end else begin
          rx_phase_next = ttu_pkg::PH_DATA;
          rx_timer_next = rx_bit_ticks;
        end
      end
      ttu_pkg::PH_DATA: begin
        if (rx_timer != '0) begin
          rx_timer_next = rx_timer - 16'd1;
        end else begin
          if (tick.rx_line) begin
            rx_shift_next[rx_bit_count[2:0]] = 1'b1;
          end
          rx_bit_count_next = rx_cnt_inc;
          if (rx_cnt_inc >= 4'd8) begin
            rx_phase_next = ttu_pkg::PH_STOP;
            rx_timer_next = rx_stop_ticks;
          end else begin
            rx_timer_next = rx_bit_ticks;
          end
        end
      end
      ttu_pkg::PH_STOP: begin
        if (rx_timer != '0) begin
          rx_timer_next = rx_timer - 16'd1;
        end else begin
          // push the byte, or flag it lost when the ring is full
          if (ring_next(fifo_tail) != fifo_head) begin
            mem_we   = 1'b1;
            tail_mid = ring_next(fifo_tail);
          end else begin
            overflow_flag_next = 1'b1;
          end
          rx_phase_next     = ttu_pkg::PH_IDLE;
          rx_bit_count_next = '0;
        end
      end
    endcase

    fifo_head_next = fifo_head;
    fifo_tail_next = tail_mid;
    pop_ok         = 1'b0;
    case (tick.op)
      ttu_pkg::CMD_POP: begin
        if (fifo_head != tail_mid) begin
          pop_ok         = 1'b1;
          fifo_head_next = ring_next(fifo_head);
        end
      end
      ttu_pkg::CMD_FLUSH: begin
        fifo_head_next = '0;
        fifo_tail_next = '0;
      end
      ttu_pkg::CMD_CLR_OVF: begin
        overflow_flag_next = 1'b0;
      end
      default: ;
    endcase

    // occupancy after the tick
    if (fifo_tail_next >= fifo_head_next) begin
      avail = CW'(fifo_tail_next) - CW'(fifo_head_next);
    end else begin
      avail = CW'(fifo_tail_next) + CW'(FIFO_DEPTH) - CW'(fifo_head_next);
    end
  end

  // Transmitter advance, then write acceptance
  always_comb begin
    tx_phase_next     = tx_phase;
    tx_timer_next     = tx_timer;
    tx_bit_count_next = tx_bit_count;
    tx_shift_next     = tx_shift;
    tx_level_next     = tx_level;
    tx_cnt_inc        = tx_bit_count + 4'd1;
    tx_dec            = (tx_timer != '0) ? tx_timer - 17'd1 : tx_timer;
    accepted          = 1'b0;

    if (tx_phase != ttu_pkg::PH_IDLE) begin
      tx_timer_next = tx_dec;
      if (tx_dec == '0) begin
        unique case (tx_phase)
          ttu_pkg::PH_IDLE: ;
          ttu_pkg::PH_FIRST: begin
            tx_phase_next     = ttu_pkg::PH_DATA;
            tx_bit_count_next = '0;
            tx_level_next     = tx_shift[0];
            tx_timer_next     = {1'b0, tx_bit_ticks};
          end
          ttu_pkg::PH_DATA: begin
            tx_bit_count_next = tx_cnt_inc;
            if (tx_cnt_inc >= 4'd8) begin
              tx_phase_next = ttu_pkg::PH_STOP;
              tx_level_next = 1'b1;
            end else begin
              tx_shift_next = {1'b0, tx_shift[7:1]};
              tx_level_next = tx_shift[1];
            end
            tx_timer_next = {1'b0, tx_bit_ticks};
          end
          ttu_pkg::PH_STOP: begin
            tx_phase_next     = ttu_pkg::PH_IDLE;
            tx_level_next     = 1'b1;
            tx_bit_count_next = '0;
          end
        endcase
      end
    end

    // start bit is driven in the accepting tick
    if (tick.op == ttu_pkg::CMD_WRITE && tx_bit_ticks != '0 &&
        tx_phase_next == ttu_pkg::PH_IDLE) begin
      accepted          = 1'b1;
      tx_phase_next     = ttu_pkg::PH_FIRST;
      tx_shift_next     = tick.tx_data;
      tx_bit_count_next = '0;
      tx_level_next     = 1'b0;
      tx_timer_next     = {1'b0, tx_bit_ticks} + ttu_pkg::TX_START_EXTRA;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head     <= '0;
      fifo_tail     <= '0;
      overflow_flag <= 1'b0;
      rx_phase      <= ttu_pkg::PH_IDLE;
      rx_timer      <= '0;
      rx_bit_count  <= '0;
      rx_shift      <= '0;
      tx_phase      <= ttu_pkg::PH_IDLE;
      tx_timer      <= '0;
      tx_bit_count  <= '0;
      tx_shift      <= '0;
      tx_level      <= 1'b1;
    end else if (a_fire) begin
      fifo_head     <= fifo_head_next;
      fifo_tail     <= fifo_tail_next;
      overflow_flag <= overflow_flag_next;
      rx_phase      <= rx_phase_next;
      rx_timer      <= rx_timer_next;
      rx_bit_count  <= rx_bit_count_next;
      rx_shift      <= rx_shift_next;
      tx_phase      <= tx_phase_next;
      tx_timer      <= tx_timer_next;
      tx_bit_count  <= tx_bit_count_next;
      tx_shift      <= tx_shift_next;
      tx_level      <= tx_level_next;
    end
  end

  // FIFO memory: one write, two registered reads (popped entry, new head)
  always_ff @(posedge clk) begin
    if (a_fire && mem_we) begin
      fifo_store[fifo_tail] <= rx_shift_next;
    end
    rd_pop  <= fifo_store[fifo_head];
    rd_head <= fifo_store[fifo_head_next];
  end

  // Read-out stage; bypass covers a byte written in the same tick
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    b_tx_line   <= tx_level_next;
    b_tx_busy   <= (tx_phase_next != ttu_pkg::PH_IDLE);
    b_accepted  <= accepted;
    b_pop_valid <= pop_ok;
    b_pop_byp   <= mem_we && (fifo_head == fifo_tail);
    b_head_ne   <= (fifo_head_next != fifo_tail_next);
    b_head_byp  <= mem_we && (fifo_head_next == fifo_tail);
    b_wbyte     <= rx_shift_next;
    b_avail     <= avail[3:0];
    b_overflow  <= overflow_flag_next;
  end

  assign res_valid           = b_valid;
  assign res.tx_line         = b_tx_line;
  assign res.tx_busy         = b_tx_busy;
  assign res.write_accepted  = b_accepted;
  assign res.pop_valid       = b_pop_valid;
  assign res.pop_data        = !b_pop_valid ? 8'd0 : (b_pop_byp ? b_wbyte : rd_pop);
  assign res.head_data       = !b_head_ne ? 8'd0 : (b_head_byp ? b_wbyte : rd_head);
  assign res.bytes_available = b_avail;
  assign res.overflow        = b_overflow;

  // An idle transmitter always holds the line high
  a_tx_idle_high: assert property (@(posedge clk) disable iff (rst)
    (tx_phase == ttu_pkg::PH_IDLE) |-> tx_level)
    else $error("tx line low while transmitter idle");

  // Receive bit counter never passes a full byte
  a_rx_count: assert property (@(posedge clk) disable iff (rst)
    rx_bit_count <= 4'd8)
    else $error("rx bit counter out of range");

  // A byte is never written over the slot kept empty
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (a_fire && mem_we) |-> (ring_next(fifo_tail) != fifo_head))
    else $error("fifo write into full ring");

  // Every tick yields its beat in the next cycle
  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    a_fire |=> res_valid)
    else $error("tick without result beat");

endmodule

// ===== hdl/ttu_outq.sv =====
// Result queue between the back end and the result port.
`timescale 1ns / 1ps

module ttu_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  ttu_pkg::res_t res,
  output logic          credit_ok,
  output logic          empty,
  input  logic          pop,
  output ttu_pkg::res_t head
);

  localparam int PW = $clog2(ttu_pkg::OQ_DEPTH);
  localparam int CW = $clog2(ttu_pkg::OQ_DEPTH + 1);

  ttu_pkg::res_t entries [ttu_pkg::OQ_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_pop;

  // Room for the beat in flight plus one more
  assign credit_ok = (count <= CW'(ttu_pkg::OQ_DEPTH - 2));
  assign empty     = (count == '0);
  assign head      = entries[rptr];
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      entries[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (res_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CW'(res_valid) - CW'(do_pop);
    end
  end

  // Credit scheme must never overfill the queue
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (count != CW'(ttu_pkg::OQ_DEPTH) || do_pop))
    else $error("result queue overfilled");

endmodule

// ===== tb/tick_timed_uart_with_rx_fifo_check.sv =====
// Passive checker: models the UART unit tick by tick and compares every result beat.
`timescale 1ns / 1ps

module tick_timed_uart_with_rx_fifo_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  func,
  input  logic        rx_line,
  input  logic [7:0]  tx_data,
  input  logic        empty,
  input  logic        pop,
  input  logic        tx_line,
  input  logic        tx_busy,
  input  logic        write_accepted,
  input  logic [7:0]  pop_data,
  input  logic        pop_valid,
  input  logic [7:0]  head_data,
  input  logic [3:0]  bytes_available,
  input  logic        overflow,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);
  import ttu_pkg::*;

  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam int MAX_PRINTS = 100;

  // Register copies
  logic        rx_arm;
  logic [15:0] rx_center, rx_bit, rx_stop, tx_bit;

  // Receiver and its ring buffer
  logic [7:0]  fifo_mem [DEPTH];
  int unsigned rd_ptr, wr_ptr;
  logic        ovf;
  phase_t      rx_ph;
  logic [15:0] rx_cnt;
  logic [3:0]  rx_nbits;
  logic [7:0]  rx_byte;

  // Transmitter
  phase_t      tx_ph;
  logic [16:0] tx_cnt;
  logic [3:0]  tx_nbits;
  logic [7:0]  tx_byte;
  logic        tx_lvl;

  res_t        due_results [$];
  int          errors = 0;

  function automatic void clear_model();
    rx_arm = 1'b0;
    rx_center = '0;
    rx_bit = '0;
    rx_stop = '0;
    tx_bit = '0;
    foreach (fifo_mem[i]) fifo_mem[i] = 8'h00;
    rd_ptr = 0;
    wr_ptr = 0;
    ovf = 1'b0;
    rx_ph = PH_IDLE;
    rx_cnt = '0;
    rx_nbits = '0;
    rx_byte = '0;
    tx_ph = PH_IDLE;
    tx_cnt = '0;
    tx_nbits = '0;
    tx_byte = '0;
    tx_lvl = 1'b1;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_RX_ENABLE: rx_arm = val[0];
      CFG_RX_CENTER: rx_center = val;
      CFG_RX_BIT:    rx_bit = val;
      CFG_RX_STOP:   rx_stop = val;
      CFG_TX_BIT:    tx_bit = val;
      default: ;
    endcase
  endfunction

  // Receiver: start detect, centering wait, 8 samples LSB first, stop skip, push
  function automatic void rx_sample(logic line);
    int unsigned nxt;
    if (rx_ph == PH_IDLE) begin
      if (rx_arm && !line) begin
        rx_ph = PH_FIRST;
        rx_cnt = rx_center;
        rx_nbits = '0;
        rx_byte = '0;
      end
    end else if (rx_cnt != 0) begin
      rx_cnt--;
    end else begin
      case (rx_ph)
        PH_FIRST: begin
          rx_ph = PH_DATA;
          rx_cnt = rx_bit;
        end
        PH_DATA: begin
          if (line) rx_byte[rx_nbits[2:0]] = 1'b1;
          rx_nbits++;
          if (rx_nbits >= 8) begin
            rx_ph = PH_STOP;
            rx_cnt = rx_stop;
          end else begin
            rx_cnt = rx_bit;
          end
        end
        default: begin
          // stop bit done: store the byte, or flag the drop when the ring is full
          nxt = (wr_ptr + 1) % DEPTH;
          if (nxt != rd_ptr) begin
            fifo_mem[wr_ptr] = rx_byte;
            wr_ptr = nxt;
          end else begin
            ovf = 1'b1;
          end
          rx_ph = PH_IDLE;
          rx_nbits = '0;
        end
      endcase
    end
  endfunction

  // Transmitter: counts down, then moves to the next bit of the frame
  function automatic void tx_advance();
    if (tx_ph != PH_IDLE) begin
      if (tx_cnt != 0) tx_cnt--;
      if (tx_cnt == 0) begin
        case (tx_ph)
          PH_FIRST: begin
            tx_ph = PH_DATA;
            tx_nbits = '0;
            tx_lvl = tx_byte[0];
            tx_cnt = {1'b0, tx_bit};
          end
          PH_DATA: begin
            tx_nbits++;
            if (tx_nbits >= 8) begin
              tx_ph = PH_STOP;
              tx_lvl = 1'b1;
            end else begin
              tx_byte = tx_byte >> 1;
              tx_lvl = tx_byte[0];
            end
            tx_cnt = {1'b0, tx_bit};
          end
          default: begin
            tx_ph = PH_IDLE;
            tx_lvl = 1'b1;
            tx_nbits = '0;
          end
        endcase
      end
    end
  endfunction

  // One tick: receiver, then host command, then transmitter, then a new write
  function automatic res_t step_uart(logic [2:0] f, logic line, logic [7:0] d);
    res_t r;
    r = '0;
    rx_sample(line);
    case (f)
      FUNC_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.pop_data = fifo_mem[rd_ptr];
          r.pop_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      FUNC_FLUSH: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      FUNC_CLR_OVF: ovf = 1'b0;
      default: ;
    endcase
    tx_advance();
    if (f == FUNC_WRITE && tx_bit != 0 && tx_ph == PH_IDLE) begin
      r.write_accepted = 1'b1;
      tx_ph = PH_FIRST;
      tx_byte = d;
      tx_nbits = '0;
      tx_lvl = 1'b0;
      tx_cnt = {1'b0, tx_bit} + TX_START_EXTRA;
    end
    if (rd_ptr != wr_ptr) r.head_data = fifo_mem[rd_ptr];
    r.bytes_available = 4'((wr_ptr + DEPTH - rd_ptr) % DEPTH);
    r.tx_line = tx_lvl;
    r.tx_busy = (tx_ph != PH_IDLE);
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Sample both channels at each edge; compare before queuing the new tick
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      clear_model();
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with no tick pending", 8'd1, 8'd0);
        end else begin
          want = due_results.pop_front();
          check_field("tx_line", tx_line, want.tx_line);
          check_field("tx_busy", tx_busy, want.tx_busy);
          check_field("write_accepted", write_accepted, want.write_accepted);
          check_field("pop_data", pop_data, want.pop_data);
          check_field("pop_valid", pop_valid, want.pop_valid);
          check_field("head_data", head_data, want.head_data);
          check_field("bytes_available", bytes_available, want.bytes_available);
          check_field("overflow", overflow, want.overflow);
        end
      end
      if (push && !full) due_results.push_back(step_uart(func, rx_line, tx_data));
    end
    outstanding <= due_results.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/tick_timed_uart_with_rx_fifo_unit_test.sv =====
// Testbench top for the tick-timed UART unit: clock, reset, tick and config stimulus, verdict.
`timescale 1ns / 1ps

module tick_timed_uart_with_rx_fifo_unit_test;
  import ttu_pkg::*;

  // func codes with no command behind them
  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;
  localparam logic [2:0] CFG_SPARE    = 3'd7;

  localparam int CYCLE_LIMIT = 700000;
  localparam int FRAME_MAX_TICKS = 64;
  localparam int TAIL_CYCLES = 20;
  localparam int DIRECTED_TICKS = 24;

  logic        clk = 1'b0;
  logic        rst;
  logic        push, full;
  logic [2:0]  func;
  logic        rx_line;
  logic [7:0]  tx_data;
  logic        empty, pop;
  logic        tx_line, tx_busy, write_accepted, pop_valid, overflow;
  logic [7:0]  pop_data, head_data;
  logic [3:0]  bytes_available;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, outstanding;
  int          cycles;

  bit          steady;
  logic        line_q [$];
  logic [15:0] cur_center, cur_bit, cur_stop;

  always #5 clk = ~clk;

  tick_timed_uart_with_rx_fifo_unit dut (.*);

  tick_timed_uart_with_rx_fifo_check u_check (.*);

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Serial frame timed so each data bit sits under the receiver's sample point
  function automatic void queue_frame(logic [7:0] b, int extra);
    int per, lead, rest;
    per = cur_bit + 1;
    lead = cur_center + cur_bit + 2 - cur_bit / 2;
    rest = cur_stop + cur_bit + 2 + extra;
    repeat (lead) line_q.push_back(1'b0);
    for (int k = 0; k < 8; k++) repeat (per) line_q.push_back(b[k]);
    repeat (rest) line_q.push_back(1'b1);
  endfunction

  // Next stretch of receive line: frames mostly, runts, idle and noise
  function automatic void plan_rx();
    int r;
    bit framed;
    framed = cur_center <= FRAME_MAX_TICKS && cur_bit <= FRAME_MAX_TICKS &&
             cur_stop <= FRAME_MAX_TICKS;
    r = $urandom_range(99);
    if (framed && r < 65) begin
      queue_frame(8'($urandom_range(255)), $urandom_range(3));
    end else if (r < 75) begin
      // runt start bit, line back high
      repeat ($urandom_range(3, 1)) line_q.push_back(1'b0);
      repeat ($urandom_range(10, 1)) line_q.push_back(1'b1);
    end else if (r < 88) begin
      repeat ($urandom_range(20, 1)) line_q.push_back(1'b1);
    end else begin
      repeat ($urandom_range(12, 1)) line_q.push_back(1'($urandom_range(1)));
    end
  endfunction

  function automatic logic next_line();
    if (line_q.size() == 0) plan_rx();
    return line_q.pop_front();
  endfunction

  function automatic logic [2:0] pick_func(int wr_w, int pop_w, int clr_w, int fl_w);
    int r;
    r = $urandom_range(99);
    if (r < wr_w) return FUNC_WRITE;
    r -= wr_w;
    if (r < pop_w) return FUNC_POP;
    r -= pop_w;
    if (r < clr_w) return FUNC_CLR_OVF;
    r -= clr_w;
    if (r < fl_w) return FUNC_FLUSH;
    r -= fl_w;
    if (r < 3) return 3'($urandom_range(FUNC_SPARE_C, FUNC_SPARE_A));
    return FUNC_TICK;
  endfunction

  // One tick beat; returns right after the edge that takes it
  task automatic send_tick(logic [2:0] f, logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    rx_line <= next_line();
    tx_data <= d;
    do @(posedge clk); while (full);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_uart(logic en, logic [15:0] c, logic [15:0] b, logic [15:0] s,
                          logic [15:0] t);
    cfg_write(CFG_RX_ENABLE, {15'd0, en});
    cfg_write(CFG_RX_CENTER, c);
    cfg_write(CFG_RX_BIT, b);
    cfg_write(CFG_RX_STOP, s);
    cfg_write(CFG_TX_BIT, t);
    cfg_valid <= 1'b0;
    cur_center = c;
    cur_bit = b;
    cur_stop = s;
  endtask

  // Sender holds off until every result has come back
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_phase(int n, int wr_w, int pop_w, int clr_w, int fl_w);
    repeat (n) send_tick(pick_func(wr_w, pop_w, clr_w, fl_w), 8'($urandom_range(255)));
    wait_drained();
  endtask

  // Result side: pop with random stalls
  initial begin
    int gap;
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    logic [2:0] f;
    logic [7:0] d;
    rst <= 1'b1;
    push <= 1'b0;
    func <= FUNC_TICK;
    rx_line <= 1'b1;
    tx_data <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RX_ENABLE;
    cfg_data <= 16'h0000;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cfg_write(CFG_SPARE, 16'hFFFF);
    set_uart(1'b1, 16'd0, 16'd0, 16'd0, 16'd1);

    // Directed: writes (accepted, refused busy, accepted after frame end),
    // pop on empty, clear, flush, unused codes, two received bytes popped
    queue_frame(8'hA5, 0);
    queue_frame(8'h5A, 0);
    for (int i = 0; i < DIRECTED_TICKS; i++) begin
      d = 8'h00;
      case (i)
        0: begin
          f = FUNC_WRITE;
          d = 8'hFF;
        end
        1, 21: f = FUNC_WRITE;
        2, 12, 23: f = FUNC_POP;
        3: f = FUNC_CLR_OVF;
        4: f = FUNC_FLUSH;
        5, 6, 7: f = FUNC_SPARE_A + 3'(i - 5);
        default: f = FUNC_TICK;
      endcase
      send_tick(f, d);
    end
    wait_drained();

    // Moderate timing, mixed traffic
    set_uart(1'b1, 16'd1, 16'd3, 16'd1, 16'd2);
    run_phase(300, 8, 15, 2, 2);

    // Fastest timing, no pops: ring fills and overflows, clears race drops
    set_uart(1'b1, 16'd0, 16'd0, 16'd0, 16'd1);
    run_phase(400, 5, 0, 6, 0);

    // Receiver disarmed (frame in flight finishes), transmitter off
    set_uart(1'b0, 16'd2, 16'd1, 16'd3, 16'd0);
    run_phase(160, 15, 20, 2, 1);

    set_uart(1'b1, 16'd5, 16'd7, 16'd0, 16'd3);
    run_phase(300, 8, 12, 2, 2);

    // No idling on either side
    steady = 1'b1;
    set_uart(1'b1, 16'd0, 16'd1, 16'd2, 16'd1);
    run_phase(300, 10, 15, 2, 2);
    steady = 1'b0;

    // Largest timer values
    set_uart(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(100, 10, 10, 2, 2);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
